// ===== hdl/ffca_pkg.sv =====
// ----------------------------------------------------------------------------
// ffca_pkg
// shared types and constants for the first-fit contiguous block allocator
// ----------------------------------------------------------------------------
package ffca_pkg;

	localparam int NUM_BLOCKS_DEF = 128;
	localparam int MAX_ALLOCS_DEF = 16;

	localparam int LEN_W    = 8;
	localparam int BIU_W    = 8;
	localparam int STATUS_W = 2;
	localparam int START_W  = 7;
	localparam int INDEX_W  = 4;

	localparam logic [BIU_W-1:0] BIU_RESET = 8'd128;

	typedef enum logic [STATUS_W-1:0] {
		ST_GRANTED = 2'd0,
		ST_FULL    = 2'd1,
		ST_NOSPACE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_MARK
	} state_t;

	typedef struct packed {
		logic    clear;
		logic    load;
		logic    scan;
		logic    mark;
		logic    finish;
		status_t code;
	} ctl_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic full;
		logic zero_len;
		logic found;
		logic exhausted;
		logic mark_last;
	} dp_stat_t;

endpackage

// ===== hdl/first_fit_contiguous_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_contiguous_allocator
// first-fit allocator of contiguous block runs over a one-bit occupancy map
// ----------------------------------------------------------------------------
// usage:
//   a request word (request_length) is taken at a clock edge with start high
//   and busy low. one result word (status, first_block, alloc_index) follows,
//   shown for exactly one cycle with done high; the receiver cannot stall it.
//   blocks_in_use must be written with blocks_in_use_we only while no
//   request is open; the block itself does not enforce this.
// sequence:
//   table full or zero length: result straight from the check, no scan.
//   otherwise the map ram is read one block per cycle from block 0 until a
//   run fits or min(blocks_in_use, NUM_BLOCKS) blocks are read, then each
//   granted block is marked in the map. busy is low again in the cycle
//   that done is shown.
// reset:
//   count cleared, blocks_in_use back to 128, then the map ram is swept to
//   free, one block per cycle from block 0 to the last, with busy held high.
// ----------------------------------------------------------------------------
module first_fit_contiguous_allocator
	import ffca_pkg::*;
#(
	parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
	parameter int MAX_ALLOCS = MAX_ALLOCS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [LEN_W-1:0]    request_length,
	input  logic                blocks_in_use_we,
	input  logic [BIU_W-1:0]    blocks_in_use,
	output logic                done,
	output logic [STATUS_W-1:0] status,
	output logic [START_W-1:0]  first_block,
	output logic [INDEX_W-1:0]  alloc_index
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	ffca_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	ffca_dpath #(
		.NUM_BLOCKS (NUM_BLOCKS),
		.MAX_ALLOCS (MAX_ALLOCS)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.request_length   (request_length),
		.blocks_in_use_we (blocks_in_use_we),
		.blocks_in_use    (blocks_in_use),
		.done             (done),
		.status           (status),
		.first_block      (first_block),
		.alloc_index      (alloc_index)
	);

endmodule

// ===== hdl/ffca_ram.sv =====
// ----------------------------------------------------------------------------
// ffca_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module ffca_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/ffca_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffca_ctrl
// sequencer: map clear after reset, request check, scan, mark, result
// ----------------------------------------------------------------------------
module ffca_ctrl
	import ffca_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd,
	output logic     busy
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.code   = ST_NOSPACE;
		busy       = 1'b1;
		case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.full) begin
					cmd.finish = 1'b1;
					cmd.code   = ST_FULL;
					state_d    = S_IDLE;
				end else if (stat.zero_len) begin
					cmd.finish = 1'b1;
					cmd.code   = ST_NOSPACE;
					state_d    = S_IDLE;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.found) begin
					state_d = S_MARK;
				end else if (stat.exhausted) begin
					cmd.finish = 1'b1;
					cmd.code   = ST_NOSPACE;
					state_d    = S_IDLE;
				end
			end
			S_MARK: begin
				cmd.mark = 1'b1;
				if (stat.mark_last) begin
					cmd.finish = 1'b1;
					cmd.code   = ST_GRANTED;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/ffca_dpath.sv =====
// ----------------------------------------------------------------------------
// ffca_dpath
// occupancy map ram, scan counters, run tracking, allocation count, result
// ----------------------------------------------------------------------------
module ffca_dpath
	import ffca_pkg::*;
#(
	parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
	parameter int MAX_ALLOCS = MAX_ALLOCS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ctl_cmd_t            cmd,
	output dp_stat_t            stat,
	input  logic [LEN_W-1:0]    request_length,
	input  logic                blocks_in_use_we,
	input  logic [BIU_W-1:0]    blocks_in_use,
	output logic                done,
	output logic [STATUS_W-1:0] status,
	output logic [START_W-1:0]  first_block,
	output logic [INDEX_W-1:0]  alloc_index
);

	localparam int BW = $clog2(NUM_BLOCKS);
	localparam int CW = BW + 1;
	localparam int LW = (CW > BIU_W) ? CW : BIU_W;
	localparam int AW = $clog2(MAX_ALLOCS + 1);
	localparam int SW = (BW > START_W) ? BW : START_W;
	localparam int XW = (AW > INDEX_W) ? AW : INDEX_W;

	logic [BIU_W-1:0]    biu_q;
	logic [AW-1:0]       count_q;
	logic [LEN_W-1:0]    len_q;
	logic [CW-1:0]       rd_idx_q;
	logic                pend_s1;
	logic [BW-1:0]       idx_s1;
	logic [LEN_W-1:0]    run_q;
	logic [BW-1:0]       run_start_q;
	logic [BW-1:0]       mk_addr_q;
	logic [LEN_W-1:0]    mk_cnt_q;
	logic                done_q;
	logic [STATUS_W-1:0] status_q;
	logic [START_W-1:0]  start_q;
	logic [INDEX_W-1:0]  index_q;

	logic [LW-1:0]    limit;
	logic [LW-1:0]    biu_ext;
	logic             issue;
	logic             map_bit;
	logic [LEN_W-1:0] run_inc;
	logic [BW-1:0]    cand_start;
	logic [SW-1:0]    start_ext;
	logic [XW-1:0]    index_ext;

	ffca_ram #(
		.WIDTH (1),
		.DEPTH (NUM_BLOCKS)
	) u_map (
		.clk   (clk),
		.we    (cmd.clear | cmd.mark),
		.waddr (mk_addr_q),
		.wdata (cmd.mark),
		.raddr (rd_idx_q[BW-1:0]),
		.rdata (map_bit)
	);

	assign biu_ext    = LW'(biu_q);
	assign limit      = (biu_ext > LW'(NUM_BLOCKS)) ? LW'(NUM_BLOCKS) : biu_ext;
	assign issue      = LW'(rd_idx_q) < limit;
	assign run_inc    = run_q + LEN_W'(1);
	assign cand_start = (run_q == '0) ? idx_s1 : run_start_q;
	assign start_ext  = SW'(run_start_q);
	assign index_ext  = XW'(count_q);

	always_comb begin
		stat            = '0;
		stat.clear_last = mk_addr_q == BW'(NUM_BLOCKS - 1);
		stat.full       = count_q >= AW'(MAX_ALLOCS);
		stat.zero_len   = len_q == '0;
		stat.found      = pend_s1 && !map_bit && (run_inc == len_q);
		stat.exhausted  = !pend_s1 && !issue;
		stat.mark_last  = mk_cnt_q == LEN_W'(1);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			biu_q     <= BIU_RESET;
			count_q   <= '0;
			mk_addr_q <= '0;
			pend_s1   <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			if (blocks_in_use_we) begin
				biu_q <= blocks_in_use;
			end
			if (cmd.load) begin
				pend_s1 <= 1'b0;
			end else if (cmd.scan) begin
				pend_s1 <= issue;
			end
			if (cmd.clear || cmd.mark) begin
				mk_addr_q <= mk_addr_q + BW'(1);
			end else if (cmd.scan && stat.found) begin
				mk_addr_q <= cand_start;
			end
			done_q <= cmd.finish;
			if (cmd.finish && cmd.code == ST_GRANTED) begin
				count_q <= count_q + AW'(1);
			end
		end
	end

	// scan and result payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			len_q    <= request_length;
			rd_idx_q <= '0;
			run_q    <= '0;
		end
		if (cmd.scan) begin
			if (issue) begin
				rd_idx_q <= rd_idx_q + CW'(1);
				idx_s1   <= rd_idx_q[BW-1:0];
			end
			if (pend_s1) begin
				if (!map_bit) begin
					run_start_q <= cand_start;
					run_q       <= run_inc;
				end else begin
					run_q <= '0;
				end
			end
			if (stat.found) begin
				mk_cnt_q <= len_q;
			end
		end
		if (cmd.mark) begin
			mk_cnt_q <= mk_cnt_q - LEN_W'(1);
		end
		if (cmd.finish) begin
			status_q <= cmd.code;
			if (cmd.code == ST_GRANTED) begin
				start_q <= start_ext[START_W-1:0];
				index_q <= index_ext[INDEX_W-1:0];
			end else begin
				start_q <= '0;
				index_q <= '0;
			end
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign first_block = start_q;
	assign alloc_index = index_q;

endmodule

// ===== hdl/ffca_checker.sv =====
// ----------------------------------------------------------------------------
// ffca_checker
// port-level checks on request and result word sequencing
// ----------------------------------------------------------------------------
module ffca_checker
	import ffca_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input logic [STATUS_W-1:0] status,
	input logic [START_W-1:0]  first_block,
	input logic [INDEX_W-1:0]  alloc_index
);

	// an accepted word keeps the block busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	// a result only follows busy work
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result word without preceding work");

	// result strobes are single and separated
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// refused words carry zero payload
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_GRANTED |-> first_block == '0 && alloc_index == '0)
		else $error("refused word with nonzero payload");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status == ST_GRANTED || status == ST_FULL || status == ST_NOSPACE)
		else $error("undefined status code");

endmodule

bind first_fit_contiguous_allocator ffca_checker u_ffca_checker (.*);

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// first-fit allocator check: a table of directed requests, then random phases
// that change the block total between them. untyped result words are checked
// against a cycle-free allocation predictor that keeps its own occupancy map.
// ----------------------------------------------------------------------------
module testbench;
	import ffca_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_TARGET = 1750;
	localparam int QUIET_TAIL  = 200;
	localparam int SETTLE_CYC  = 2 * NUM_BLOCKS_DEF + 40;

	typedef struct {
		status_t              status;
		logic [START_W-1:0]   first_block;
		logic [INDEX_W-1:0]   alloc_index;
	} alloc_word_t;

	typedef struct {
		bit                 wr_total;
		logic [BIU_W-1:0]   total;
		logic [LEN_W-1:0]   len;
		bit                 typed;
		alloc_word_t        word;
	} request_row_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [LEN_W-1:0]    request_length = '0;
	logic                blocks_in_use_we = 1'b0;
	logic [BIU_W-1:0]    blocks_in_use = BIU_RESET;
	logic                done;
	logic [STATUS_W-1:0] status;
	logic [START_W-1:0]  first_block;
	logic [INDEX_W-1:0]  alloc_index;

	// predictor state
	bit                  block_used [NUM_BLOCKS_DEF];
	int                  grants_made = 0;
	logic [BIU_W-1:0]    total_cfg = BIU_RESET;

	alloc_word_t         pending_words [$];
	request_row_t        request_table [$];
	int                  err_count = 0;
	int                  items_sent = 0;
	int                  totals_used = 0;
	int                  granted_seen = 0;
	int                  nospace_seen = 0;
	int                  full_seen = 0;

	first_fit_contiguous_allocator #(
		.NUM_BLOCKS(NUM_BLOCKS_DEF),
		.MAX_ALLOCS(MAX_ALLOCS_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request_length(request_length),
		.blocks_in_use_we(blocks_in_use_we),
		.blocks_in_use(blocks_in_use),
		.done(done),
		.status(status),
		.first_block(first_block),
		.alloc_index(alloc_index)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#60_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic int usable_limit();
		return (total_cfg > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : int'(total_cfg);
	endfunction

	function automatic alloc_word_t predict_alloc(input logic [LEN_W-1:0] len);
		alloc_word_t w;
		int limit;
		int run;
		int run_first;
		int found;
		int b;
		w.status = ST_NOSPACE;
		w.first_block = '0;
		w.alloc_index = '0;
		if (grants_made >= MAX_ALLOCS_DEF) begin
			w.status = ST_FULL;
			return w;
		end
		limit = usable_limit();
		run = 0;
		run_first = 0;
		found = -1;
		if (len != 0) begin
			for (b = 0; b < limit && found < 0; b++) begin
				if (!block_used[b]) begin
					if (run == 0)
						run_first = b;
					run++;
					if (run == int'(len))
						found = run_first;
				end else begin
					run = 0;
				end
			end
		end
		if (found < 0)
			return w;
		for (b = found; b < found + int'(len); b++)
			block_used[b] = 1'b1;
		w.status = ST_GRANTED;
		w.first_block = START_W'(found);
		w.alloc_index = INDEX_W'(grants_made);
		grants_made++;
		return w;
	endfunction

	function automatic int widest_free_run();
		int limit;
		int run;
		int widest;
		int b;
		limit = usable_limit();
		run = 0;
		widest = 0;
		for (b = 0; b < limit; b++) begin
			run = block_used[b] ? 0 : run + 1;
			if (run > widest)
				widest = run;
		end
		return widest;
	endfunction

	// mostly lengths that miss, so grants spread over the run
	function automatic logic [LEN_W-1:0] pick_length();
		int widest;
		int r;
		if (grants_made >= MAX_ALLOCS_DEF)
			return LEN_W'($urandom_range(0, 255));
		widest = widest_free_run();
		r = $urandom_range(0, 999);
		if (r < 15 && widest > 0) begin
			if (widest <= 16 && $urandom_range(0, 2) == 0)
				return LEN_W'(widest);
			return LEN_W'($urandom_range(1, (widest < 8) ? widest : 8));
		end
		if (r < 40)
			return '0;
		if (widest >= 255)
			return LEN_W'($urandom_range(0, 255));
		if (r < 100)
			return LEN_W'(widest + 1);
		return LEN_W'($urandom_range(widest + 1, 255));
	endfunction

	function automatic logic [BIU_W-1:0] pick_total();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd2;
			3: return 8'd127;
			4: return 8'd128;
			5: return 8'd129;
			6: return 8'd255;
			default: return BIU_W'($urandom_range(3, 254));
		endcase
	endfunction

	task automatic add_row(input bit wr, input logic [BIU_W-1:0] total,
			input logic [LEN_W-1:0] len, input bit typed, input status_t st,
			input int sb, input int ix);
		request_row_t row;
		row.wr_total = wr;
		row.total = total;
		row.len = len;
		row.typed = typed;
		row.word.status = st;
		row.word.first_block = START_W'(sb);
		row.word.alloc_index = INDEX_W'(ix);
		request_table.push_back(row);
	endtask

	task automatic hold_off(input int n);
		repeat (n) @(negedge clk) start <= 1'b0;
	endtask

	task automatic wait_drained();
		@(negedge clk) start <= 1'b0;
		while (pending_words.size() != 0 || busy !== 1'b0)
			@(posedge clk);
	endtask

	task automatic write_total(input logic [BIU_W-1:0] value);
		wait_drained();
		@(negedge clk);
		blocks_in_use_we <= 1'b1;
		blocks_in_use <= value;
		total_cfg = value;
		@(negedge clk) blocks_in_use_we <= 1'b0;
		totals_used++;
	endtask

	task automatic send_word(input logic [LEN_W-1:0] len, input bit typed,
			input alloc_word_t typed_word);
		alloc_word_t w;
		@(negedge clk);
		start <= 1'b1;
		request_length <= len;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		w = predict_alloc(len);
		pending_words.push_back(typed ? typed_word : w);
		items_sent++;
	endtask

	task automatic note_error(input string msg);
		if (err_count < 10)
			$display("%0t: %s", $time, msg);
		err_count++;
	endtask

	always @(posedge clk) begin
		alloc_word_t w;
		if (arst_n && done === 1'b1) begin
			if (pending_words.size() == 0) begin
				note_error($sformatf({"result word with nothing pending: ",
					"status %0d start %0d index %0d"},
					status, first_block, alloc_index));
			end else begin
				w = pending_words.pop_front();
				case (w.status)
					ST_GRANTED: granted_seen++;
					ST_FULL:    full_seen++;
					default:    nospace_seen++;
				endcase
				if (status !== w.status || first_block !== w.first_block ||
						alloc_index !== w.alloc_index)
					note_error($sformatf({"mismatch: expected status %0d start %0d index %0d, ",
						"got status %0d start %0d index %0d"},
						w.status, w.first_block, w.alloc_index,
						status, first_block, alloc_index));
			end
		end
	end

	initial begin
		alloc_word_t dummy;
		request_row_t row;
		int phase_items;
		int k;
		bit calm;
		dummy.status = ST_NOSPACE;
		dummy.first_block = '0;
		dummy.alloc_index = '0;
		for (k = 0; k < NUM_BLOCKS_DEF; k++)
			block_used[k] = 1'b0;

		// zero length, oversize lengths, zero total, single block, saturated total
		add_row(0, 8'd0,   8'd0,   1, ST_NOSPACE, 0, 0);
		add_row(0, 8'd0,   8'd255, 1, ST_NOSPACE, 0, 0);
		add_row(0, 8'd0,   8'd129, 1, ST_NOSPACE, 0, 0);
		add_row(1, 8'd0,   8'd1,   1, ST_NOSPACE, 0, 0);
		add_row(0, 8'd0,   8'd128, 1, ST_NOSPACE, 0, 0);
		add_row(1, 8'd1,   8'd2,   1, ST_NOSPACE, 0, 0);
		add_row(0, 8'd0,   8'd1,   1, ST_GRANTED, 0, 0);
		add_row(0, 8'd0,   8'd1,   1, ST_NOSPACE, 0, 0);
		add_row(1, 8'd255, 8'd128, 1, ST_NOSPACE, 0, 0);
		add_row(0, 8'd0,   8'd3,   0, ST_GRANTED, 0, 0);
		add_row(1, 8'd10,  8'd6,   0, ST_GRANTED, 0, 0);
		add_row(0, 8'd0,   8'd1,   0, ST_GRANTED, 0, 0);
		add_row(1, 8'd128, 8'd119, 0, ST_GRANTED, 0, 0);
		add_row(1, 8'd129, 8'd119, 0, ST_GRANTED, 0, 0);
		add_row(1, 8'd2,   8'd1,   0, ST_GRANTED, 0, 0);
		add_row(1, 8'd127, 8'd2,   0, ST_GRANTED, 0, 0);
		add_row(0, 8'd0,   8'd127, 0, ST_GRANTED, 0, 0);
		add_row(0, 8'd0,   8'd170, 0, ST_GRANTED, 0, 0);

		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		foreach (request_table[i]) begin
			row = request_table[i];
			if (row.wr_total)
				write_total(row.total);
			send_word(row.len, row.typed, row.word);
		end

		while (items_sent < ITEM_TARGET) begin
			write_total(pick_total());
			phase_items = $urandom_range(30, 110);
			calm = ($urandom_range(0, 2) == 0);
			for (k = 0; k < phase_items && items_sent < ITEM_TARGET; k++) begin
				if (items_sent >= ITEM_TARGET - QUIET_TAIL)
					calm = 1'b1;
				if (!calm && $urandom_range(0, 3) == 0)
					hold_off($urandom_range(1, 7));
				else if (!calm && $urandom_range(0, 99) == 0)
					wait_drained();
				send_word(pick_length(), 1'b0, dummy);
			end
		end

		wait_drained();
		repeat (SETTLE_CYC) @(posedge clk);
		if (pending_words.size() != 0)
			note_error($sformatf("%0d result words never arrived", pending_words.size()));

		$display("%0d requests over %0d block-total settings: %0d granted, %0d no space,",
			items_sent, totals_used, granted_seen, nospace_seen);
		$display("%0d table full; %0d mismatches", full_seen, err_count);
		if (err_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
